// ===== rtl/lsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LIN slave frame handler package
// Word layouts, command and status bundles between controller and datapath,
// result codes and the small arithmetic helpers of the frame handler.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int unsigned SLOTS_DEF     = 8;
  localparam int unsigned MAX_BYTES_DEF = 8;
  localparam int unsigned ID_COUNT_DEF  = 64;

  localparam logic [2:0] OP_BREAK    = 3'd0;
  localparam logic [2:0] OP_BUS_BYTE = 3'd1;
  localparam logic [2:0] OP_TABLE_WR = 3'd2;
  localparam logic [2:0] OP_DATA_WR  = 3'd3;
  localparam logic [2:0] OP_DATA_RD  = 3'd4;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SYNC_ERR   = 3'd1;
  localparam logic [2:0] ST_PARITY_ERR = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_ID = 3'd3;
  localparam logic [2:0] ST_CSUM_ERR   = 3'd4;
  localparam logic [2:0] ST_BAD_ACCESS = 3'd5;

  localparam logic [7:0] SYNC_FIELD = 8'h55;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [5:0] frame_id;
    logic       entry_valid;
    logic [2:0] entry_slot;
    logic       entry_publish;
    logic [3:0] entry_length;
    logic [2:0] byte_index;
  } lsf_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [2:0] frame_slot;
    logic       last;
  } lsf_rsp_t;

  typedef enum logic [0:0] {
    AS_PUB    = 1'b0,
    AS_ACCESS = 1'b1
  } addr_sel_t;

  typedef enum logic [1:0] {
    WS_NONE   = 2'd0,
    WS_CLEAR  = 2'd1,
    WS_ACCESS = 2'd2,
    WS_COPY   = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    BS_ZERO  = 2'd0,
    BS_RDATA = 2'd1,
    BS_CSUM  = 2'd2
  } byte_sel_t;

  typedef enum logic [1:0] {
    SS_ZERO   = 2'd0,
    SS_ENTRY  = 2'd1,
    SS_LOOKUP = 2'd2
  } slot_sel_t;

  typedef struct packed {
    logic       latch;
    logic       hdr_clear;
    logic       rx_store;
    logic       id_rd;
    logic       id_pid;
    logic       id_wr;
    logic       entry_load;
    logic       ds_rd;
    addr_sel_t  addr_sel;
    wr_sel_t    ds_wr;
    logic       pub_add;
    logic       copy_step;
    logic       emit;
    logic [1:0] kind;
    logic [2:0] status;
    byte_sel_t  byte_sel;
    slot_sel_t  slot_sel;
    logic       last;
  } lsf_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sync_ok;
    logic       parity_ok;
    logic       id_valid;
    logic       id_publish;
    logic       idx_ok;
    logic       rx_room;
    logic       csum_ok;
    logic       step_last;
    logic       clr_last;
  } lsf_sts_t;

  // Eight-bit sum with end-around carry.
  function automatic logic [7:0] sum_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t > 9'd255) t = t - 9'd255;
    return t[7:0];
  endfunction

  function automatic logic [3:0] sat_len(input logic [3:0] len, input int unsigned maxb);
    logic [3:0] m;
    m = 4'(maxb);
    if (len == 4'd0) return 4'd1;
    if (len > m) return m;
    return len;
  endfunction

  // Slot reduced into the range of the data store by repeated subtraction.
  function automatic logic [2:0] slot_mod(input logic [2:0] s, input int unsigned slots);
    logic [6:0] r;
    logic [6:0] n;
    r = {4'b0000, s};
    n = 7'(slots);
    for (int i = 0; i < 8; i++) begin
      if (r >= n) r = r - n;
    end
    return r[2:0];
  endfunction

  function automatic logic pid_parity_ok(input logic [7:0] b);
    logic p0;
    logic p1;
    p0 = b[0] ^ b[1] ^ b[2] ^ b[4];
    p1 = ~(b[1] ^ b[3] ^ b[4] ^ b[5]);
    return (b[6] == p0) && (b[7] == p1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lsf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LIN slave frame handler controller
// Frame phase tracking and the sequencer that drives the datapath for each
// accepted word.
// ----------------------------------------------------------------------------
module lsf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lsf_pkg::lsf_sts_t sts,
  output lsf_pkg::lsf_cmd_t cmd
);
  import lsf_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DISPATCH = 9'b000000100,
    S_LOOKUP   = 9'b000001000,
    S_RD_WAIT  = 9'b000010000,
    S_PUB_RD   = 9'b000100000,
    S_PUB_EMIT = 9'b001000000,
    S_PUB_CSUM = 9'b010000000,
    S_COPY     = 9'b100000000
  } state_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_SYNC = 4'b0010,
    PH_PID  = 4'b0100,
    PH_RECV = 4'b1000
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    cmd.latch      = 1'b0;
    cmd.hdr_clear  = 1'b0;
    cmd.rx_store   = 1'b0;
    cmd.id_rd      = 1'b0;
    cmd.id_pid     = 1'b0;
    cmd.id_wr      = 1'b0;
    cmd.entry_load = 1'b0;
    cmd.ds_rd      = 1'b0;
    cmd.addr_sel   = AS_PUB;
    cmd.ds_wr      = WS_NONE;
    cmd.pub_add    = 1'b0;
    cmd.copy_step  = 1'b0;
    cmd.emit       = 1'b0;
    cmd.kind       = KIND_REPORT;
    cmd.status     = ST_OK;
    cmd.byte_sel   = BS_ZERO;
    cmd.slot_sel   = SS_ZERO;
    cmd.last       = 1'b1;

    case (state)
      S_CLEAR: begin
        cmd.ds_wr = WS_CLEAR;
        if (sts.clr_last) state_next = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_next = S_IDLE;
        case (sts.op)
          OP_BREAK: begin
            phase_next    = PH_SYNC;
            cmd.hdr_clear = 1'b1;
          end
          OP_BUS_BYTE: begin
            case (phase)
              PH_SYNC: begin
                if (sts.sync_ok) begin
                  phase_next = PH_PID;
                end else begin
                  phase_next = PH_IDLE;
                  cmd.emit   = 1'b1;
                  cmd.status = ST_SYNC_ERR;
                end
              end
              PH_PID: begin
                phase_next = PH_IDLE;
                if (!sts.parity_ok) begin
                  cmd.emit   = 1'b1;
                  cmd.status = ST_PARITY_ERR;
                end else begin
                  cmd.id_rd  = 1'b1;
                  cmd.id_pid = 1'b1;
                  state_next = S_LOOKUP;
                end
              end
              PH_RECV: begin
                if (sts.rx_room) begin
                  cmd.rx_store = 1'b1;
                end else begin
                  phase_next = PH_IDLE;
                  if (sts.csum_ok) begin
                    state_next = S_COPY;
                  end else begin
                    cmd.emit     = 1'b1;
                    cmd.status   = ST_CSUM_ERR;
                    cmd.slot_sel = SS_ENTRY;
                  end
                end
              end
              default: begin
                // A byte outside a frame, such as our own echo, is dropped.
              end
            endcase
          end
          OP_TABLE_WR: begin
            cmd.id_wr = 1'b1;
          end
          OP_DATA_WR, OP_DATA_RD: begin
            cmd.id_rd  = 1'b1;
            state_next = S_LOOKUP;
          end
          default: begin
          end
        endcase
      end

      S_LOOKUP: begin
        state_next = S_IDLE;
        if (sts.op == OP_BUS_BYTE) begin
          if (!sts.id_valid) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_UNKNOWN_ID;
          end else begin
            cmd.entry_load = 1'b1;
            if (sts.id_publish) begin
              state_next = S_PUB_RD;
            end else begin
              phase_next = PH_RECV;
            end
          end
        end else if (sts.op == OP_DATA_WR) begin
          cmd.emit = 1'b1;
          if (!sts.id_valid) begin
            cmd.status = ST_BAD_ACCESS;
          end else begin
            cmd.slot_sel = SS_LOOKUP;
            if (sts.idx_ok) cmd.ds_wr = WS_ACCESS;
          end
        end else begin
          cmd.kind = KIND_READ;
          if (!sts.id_valid) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_BAD_ACCESS;
          end else if (sts.idx_ok) begin
            cmd.ds_rd    = 1'b1;
            cmd.addr_sel = AS_ACCESS;
            state_next   = S_RD_WAIT;
          end else begin
            cmd.emit     = 1'b1;
            cmd.slot_sel = SS_LOOKUP;
          end
        end
      end

      S_RD_WAIT: begin
        cmd.emit     = 1'b1;
        cmd.kind     = KIND_READ;
        cmd.byte_sel = BS_RDATA;
        cmd.slot_sel = SS_LOOKUP;
        state_next   = S_IDLE;
      end

      S_PUB_RD: begin
        cmd.ds_rd    = 1'b1;
        cmd.addr_sel = AS_PUB;
        state_next   = S_PUB_EMIT;
      end

      S_PUB_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.kind     = KIND_TX;
        cmd.byte_sel = BS_RDATA;
        cmd.slot_sel = SS_ENTRY;
        cmd.last     = 1'b0;
        cmd.pub_add  = 1'b1;
        state_next   = sts.step_last ? S_PUB_CSUM : S_PUB_RD;
      end

      S_PUB_CSUM: begin
        cmd.emit     = 1'b1;
        cmd.kind     = KIND_TX;
        cmd.byte_sel = BS_CSUM;
        cmd.slot_sel = SS_ENTRY;
        state_next   = S_IDLE;
      end

      S_COPY: begin
        cmd.ds_wr     = WS_COPY;
        cmd.copy_step = 1'b1;
        if (sts.step_last) begin
          cmd.emit     = 1'b1;
          cmd.slot_sel = SS_ENTRY;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lsf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LIN slave frame handler datapath
// Frame table, data store, receive buffer, checksum accumulator and the
// result register, all steered by the controller.
// ----------------------------------------------------------------------------
module lsf_datapath #(
  parameter int unsigned SLOTS     = lsf_pkg::SLOTS_DEF,
  parameter int unsigned MAX_BYTES = lsf_pkg::MAX_BYTES_DEF,
  parameter int unsigned ID_COUNT  = lsf_pkg::ID_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lsf_pkg::lsf_req_t req,
  input  lsf_pkg::lsf_cmd_t cmd,
  output lsf_pkg::lsf_sts_t sts,
  output lsf_pkg::lsf_rsp_t rsp,
  output logic              rsp_strobe
);
  import lsf_pkg::*;

  localparam int unsigned DEPTH = SLOTS * MAX_BYTES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MW    = AW + 4;
  localparam int unsigned IW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned ID_W  = $clog2(ID_COUNT);

  lsf_req_t req_q;

  // Frame table: slot, publish flag and length in memory, valid bits in flops.
  logic [7:0]          id_mem [ID_COUNT];
  logic [ID_COUNT-1:0] id_vld;
  logic [7:0]          id_q;
  logic                id_vld_q;
  logic [ID_W-1:0]     id_addr;

  logic [7:0]    ds_mem [DEPTH];
  logic [7:0]    ds_q;
  logic [AW-1:0] clr_addr;

  logic [7:0] rbuf [MAX_BYTES];

  logic [2:0] entry_slot;
  logic [3:0] entry_len;
  logic [3:0] byte_count;
  logic [7:0] running_sum;
  logic [3:0] step;

  lsf_rsp_t rsp_q;
  logic     rsp_strobe_q;

  logic [2:0]    rd_slot, wr_slot, rd_idx, wr_idx;
  logic [MW-1:0] rd_wide, wr_wide;
  logic [7:0]    wr_data;
  logic          ds_we;

  always_ff @(posedge clk) begin
    if (cmd.latch) req_q <= req;
  end

  assign id_addr = cmd.id_pid ? req_q.data_byte[ID_W-1:0] : req_q.frame_id[ID_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.id_wr) begin
      id_mem[req_q.frame_id[ID_W-1:0]] <= {slot_mod(req_q.entry_slot, SLOTS),
                                           req_q.entry_publish,
                                           sat_len(req_q.entry_length, MAX_BYTES)};
    end
    if (cmd.id_rd) id_q <= id_mem[id_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_vld   <= '0;
      id_vld_q <= 1'b0;
    end else begin
      if (cmd.id_wr) id_vld[req_q.frame_id[ID_W-1:0]] <= req_q.entry_valid;
      if (cmd.id_rd) id_vld_q <= id_vld[id_addr];
    end
  end

  // Data store addressing: slot times bytes per slot plus byte position.
  always_comb begin
    if (cmd.addr_sel == AS_ACCESS) begin
      rd_slot = id_q[7:5];
      rd_idx  = req_q.byte_index;
    end else begin
      rd_slot = entry_slot;
      rd_idx  = step[2:0];
    end
    wr_slot = (cmd.ds_wr == WS_ACCESS) ? id_q[7:5] : entry_slot;
    wr_idx  = (cmd.ds_wr == WS_ACCESS) ? req_q.byte_index : step[2:0];
    rd_wide = MW'(rd_slot) * MW'(MAX_BYTES) + MW'(rd_idx);
    wr_wide = MW'(wr_slot) * MW'(MAX_BYTES) + MW'(wr_idx);
    case (cmd.ds_wr)
      WS_ACCESS: wr_data = req_q.data_byte;
      WS_COPY:   wr_data = rbuf[step[IW-1:0]];
      default:   wr_data = 8'h00;
    endcase
  end

  assign ds_we = (cmd.ds_wr != WS_NONE);

  always_ff @(posedge clk) begin
    if (ds_we) begin
      if (cmd.ds_wr == WS_CLEAR) ds_mem[clr_addr] <= 8'h00;
      else                       ds_mem[wr_wide[AW-1:0]] <= wr_data;
    end
    if (cmd.ds_rd) ds_q <= ds_mem[rd_wide[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.ds_wr == WS_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_store) rbuf[byte_count[IW-1:0]] <= req_q.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_slot  <= 3'd0;
      entry_len   <= 4'd0;
      byte_count  <= 4'd0;
      running_sum <= 8'h00;
      step        <= 4'd0;
    end else if (cmd.entry_load) begin
      entry_slot  <= id_q[7:5];
      entry_len   <= id_q[3:0];
      byte_count  <= 4'd0;
      running_sum <= 8'h00;
      step        <= 4'd0;
    end else if (cmd.hdr_clear) begin
      byte_count  <= 4'd0;
      running_sum <= 8'h00;
    end else if (cmd.rx_store) begin
      running_sum <= sum_add(running_sum, req_q.data_byte);
      byte_count  <= byte_count + 4'd1;
    end else if (cmd.pub_add) begin
      running_sum <= sum_add(running_sum, ds_q);
      step        <= step + 4'd1;
    end else if (cmd.copy_step) begin
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_strobe_q <= 1'b0;
    end else begin
      rsp_strobe_q <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_q.kind   <= cmd.kind;
      rsp_q.status <= cmd.status;
      rsp_q.last   <= cmd.last;
      case (cmd.byte_sel)
        BS_RDATA: rsp_q.out_byte <= ds_q;
        BS_CSUM:  rsp_q.out_byte <= ~running_sum;
        default:  rsp_q.out_byte <= 8'h00;
      endcase
      case (cmd.slot_sel)
        SS_ENTRY:  rsp_q.frame_slot <= entry_slot;
        SS_LOOKUP: rsp_q.frame_slot <= id_q[7:5];
        default:   rsp_q.frame_slot <= 3'd0;
      endcase
    end
  end

  assign rsp        = rsp_q;
  assign rsp_strobe = rsp_strobe_q;

  always_comb begin
    sts.op         = req_q.opcode;
    sts.sync_ok    = (req_q.data_byte == SYNC_FIELD);
    sts.parity_ok  = pid_parity_ok(req_q.data_byte);
    sts.id_valid   = id_vld_q;
    sts.id_publish = id_q[4];
    sts.idx_ok     = ({1'b0, req_q.byte_index} < id_q[3:0]);
    sts.rx_room    = (byte_count < entry_len);
    sts.csum_ok    = (~running_sum == req_q.data_byte);
    sts.step_last  = ((step + 4'd1) == entry_len);
    sts.clr_last   = (clr_addr == AW'(DEPTH - 1));
  end

endmodule
`default_nettype wire

// ===== rtl/lin_slave_frame_handler.sv =====
`default_nettype none
// A publish response emits each byte after a data store read of it and ends with the
// checksum byte. At the end of a subscribe frame the received bytes are copied into
// the data store in order.
// Results are registered and appear in the cycle after the step that forms them, one word per strobe.
// ----------------------------------------------------------------------------
// LIN slave frame handler
// Slave node with header checking, frame table lookup, publish responses and
// subscribe reception with classic checksum. Reset clears the frame table and
// then sweeps the data store to zero.
// ----------------------------------------------------------------------------
module lin_slave_frame_handler #(
  parameter int unsigned SLOTS     = lsf_pkg::SLOTS_DEF,
  parameter int unsigned MAX_BYTES = lsf_pkg::MAX_BYTES_DEF,
  parameter int unsigned ID_COUNT  = lsf_pkg::ID_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lsf_pkg::lsf_req_t req,
  output logic              rsp_strobe,
  output lsf_pkg::lsf_rsp_t rsp
);
  import lsf_pkg::*;

  lsf_cmd_t cmd;
  lsf_sts_t sts;

  lsf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lsf_datapath #(
    .SLOTS     (SLOTS),
    .MAX_BYTES (MAX_BYTES),
    .ID_COUNT  (ID_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cmd        (cmd),
    .sts        (sts),
    .rsp        (rsp),
    .rsp_strobe (rsp_strobe)
  );

  // An accepted word always occupies the sequencer in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // Only the final word of a response may leave the sequencer idle.
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe && !rsp.last |-> busy)
    else $error("non-final result word with sequencer idle");

  a_report_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe && rsp.kind == KIND_REPORT |-> rsp.out_byte == 8'h00)
    else $error("frame report carries a data byte");

  // Transmit words only come from a publish response, which never reports errors.
  a_tx_status: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe && rsp.kind == KIND_TX |-> rsp.status == ST_OK)
    else $error("transmit word with error status");

endmodule
`default_nettype wire

// ===== test/lin_slave_frame_handler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIN slave frame handler testbench
// Drives break, bus byte, table and data access words through the start/busy
// handshake. A scoreboard tracks the node's header phase, frame table, data
// store and checksum, predicts every result word and checks the strobed
// words against it in order. Stimulus is a short directed set followed by
// randomised frames, table updates, data accesses and bus noise.
// ----------------------------------------------------------------------------
module lin_slave_frame_handler_tb;
  import lsf_pkg::*;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam int         RANDOM_WORDS    = 380;

  typedef enum logic [1:0] {
    NODE_IDLE = 2'd0,
    NODE_SYNC = 2'd1,
    NODE_PID  = 2'd2,
    NODE_RECV = 2'd3
  } node_phase_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] slot;
    logic       publish;
    logic [3:0] len;
  } frame_entry_t;

  class lin_node_scoreboard;
    node_phase_t  phase;
    frame_entry_t frame_table [64];
    logic [7:0]   slot_data [64];
    logic [7:0]   rx_bytes [8];
    logic [2:0]   rx_slot;
    logic [3:0]   rx_len;
    logic [3:0]   rx_count;
    logic [7:0]   rx_sum;
    lsf_rsp_t     awaited [$];
    int           mismatches;

    function new();
      phase      = NODE_IDLE;
      rx_slot    = '0;
      rx_len     = '0;
      rx_count   = '0;
      rx_sum     = '0;
      mismatches = 0;
      foreach (frame_table[i]) frame_table[i] = '0;
      foreach (slot_data[i]) slot_data[i] = '0;
      foreach (rx_bytes[i]) rx_bytes[i] = '0;
    endfunction

    // Classic LIN sum: any carry out of bit 7 is folded back into bit 0.
    function logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[8] ? t[7:0] + 8'd1 : t[7:0];
    endfunction

    function void push(input logic [1:0] kind, input logic [7:0] value,
                       input logic [2:0] status, input logic [2:0] slot,
                       input logic last);
      lsf_rsp_t r;
      r.kind       = kind;
      r.out_byte   = value;
      r.status     = status;
      r.frame_slot = slot;
      r.last       = last;
      awaited.push_back(r);
    endfunction

    function void header_pid(input logic [7:0] b);
      logic [5:0]   id;
      logic         p0;
      logic         p1;
      frame_entry_t e;
      logic [7:0]   v;
      logic [7:0]   sum;
      id    = b[5:0];
      p0    = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1    = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      e     = frame_table[id];
      sum   = '0;
      phase = NODE_IDLE;
      if (b[6] != p0 || b[7] != p1) begin
        push(KIND_REPORT, 8'h00, ST_PARITY_ERR, 3'd0, 1'b1);
      end else if (!e.valid) begin
        push(KIND_REPORT, 8'h00, ST_UNKNOWN_ID, 3'd0, 1'b1);
      end else if (e.publish) begin
        for (int i = 0; i < e.len; i++) begin
          v   = slot_data[{e.slot, 3'(i)}];
          sum = add_carry(sum, v);
          push(KIND_TX, v, ST_OK, e.slot, 1'b0);
        end
        push(KIND_TX, ~sum, ST_OK, e.slot, 1'b1);
      end else begin
        rx_slot  = e.slot;
        rx_len   = e.len;
        rx_count = '0;
        rx_sum   = '0;
        phase    = NODE_RECV;
      end
    endfunction

    function void response_byte(input logic [7:0] b);
      if (rx_count < rx_len) begin
        rx_bytes[rx_count[2:0]] = b;
        rx_sum   = add_carry(rx_sum, b);
        rx_count = rx_count + 4'd1;
      end else begin
        phase = NODE_IDLE;
        if (~rx_sum == b) begin
          for (int i = 0; i < rx_len; i++) slot_data[{rx_slot, 3'(i)}] = rx_bytes[i];
          push(KIND_REPORT, 8'h00, ST_OK, rx_slot, 1'b1);
        end else begin
          push(KIND_REPORT, 8'h00, ST_CSUM_ERR, rx_slot, 1'b1);
        end
      end
    endfunction

    function void note_word(input lsf_req_t w);
      frame_entry_t e;
      logic [3:0]   len;
      e = frame_table[w.frame_id];
      case (w.opcode)
        OP_BREAK: begin
          phase    = NODE_SYNC;
          rx_count = '0;
          rx_sum   = '0;
        end
        OP_BUS_BYTE: begin
          case (phase)
            NODE_SYNC: begin
              if (w.data_byte == SYNC_FIELD) begin
                phase = NODE_PID;
              end else begin
                phase = NODE_IDLE;
                push(KIND_REPORT, 8'h00, ST_SYNC_ERR, 3'd0, 1'b1);
              end
            end
            NODE_PID:  header_pid(w.data_byte);
            NODE_RECV: response_byte(w.data_byte);
            default: ;
          endcase
        end
        OP_TABLE_WR: begin
          len = w.entry_length;
          if (len == 4'd0) len = 4'd1;
          if (len > MAX_BYTES_DEF) len = 4'(MAX_BYTES_DEF);
          frame_table[w.frame_id] = {w.entry_valid, w.entry_slot, w.entry_publish, len};
        end
        OP_DATA_WR: begin
          if (!e.valid) begin
            push(KIND_REPORT, 8'h00, ST_BAD_ACCESS, 3'd0, 1'b1);
          end else begin
            if (w.byte_index < e.len) slot_data[{e.slot, w.byte_index}] = w.data_byte;
            push(KIND_REPORT, 8'h00, ST_OK, e.slot, 1'b1);
          end
        end
        OP_DATA_RD: begin
          if (!e.valid) push(KIND_READ, 8'h00, ST_BAD_ACCESS, 3'd0, 1'b1);
          else push(KIND_READ, (w.byte_index < e.len) ? slot_data[{e.slot, w.byte_index}]
                                                       : 8'h00, ST_OK, e.slot, 1'b1);
        end
        default: ;
      endcase
    endfunction

    // Fields are listed as kind, byte, status, slot, last.
    function void check_word(input lsf_rsp_t got);
      lsf_rsp_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word: %0d %02h %0d %0d %0b",
                   $realtime, got.kind, got.out_byte, got.status, got.frame_slot, got.last);
        return;
      end
      exp = awaited.pop_front();
      if (got.kind !== exp.kind || got.out_byte !== exp.out_byte ||
          got.status !== exp.status || got.frame_slot !== exp.frame_slot ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word differs: expected %0d %02h %0d %0d %0b, got %0d %02h %0d %0d %0b",
                   $realtime, exp.kind, exp.out_byte, exp.status, exp.frame_slot, exp.last,
                   got.kind, got.out_byte, got.status, got.frame_slot, got.last);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  lsf_req_t req;
  logic     rsp_strobe;
  lsf_rsp_t rsp;

  lin_node_scoreboard sb = new();
  int items;
  bit gaps_on;

  lin_slave_frame_handler dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .rsp_strobe (rsp_strobe),
    .rsp        (rsp)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_strobe) sb.check_word(rsp);
      if (start && !busy) sb.note_word(req);
    end
  end

  function automatic lsf_req_t make_word(input logic [2:0] op, input logic [7:0] data,
                                         input logic [5:0] id, input logic [2:0] idx);
    lsf_req_t w;
    w.opcode        = op;
    w.data_byte     = data;
    w.frame_id      = id;
    w.entry_valid   = 1'($urandom_range(1));
    w.entry_slot    = 3'($urandom_range(7));
    w.entry_publish = 1'($urandom_range(1));
    w.entry_length  = 4'($urandom_range(15));
    w.byte_index    = idx;
    return w;
  endfunction

  function automatic lsf_req_t table_word(input logic [5:0] id, input logic valid,
                                          input logic [2:0] slot, input logic publish,
                                          input logic [3:0] len);
    lsf_req_t w;
    w               = make_word(OP_TABLE_WR, 8'($urandom_range(255)), id,
                                3'($urandom_range(7)));
    w.entry_valid   = valid;
    w.entry_slot    = slot;
    w.entry_publish = publish;
    w.entry_length  = len;
    return w;
  endfunction

  function automatic logic [7:0] protected_id(input logic [5:0] id);
    return {~(id[1] ^ id[3] ^ id[4] ^ id[5]), id[0] ^ id[1] ^ id[2] ^ id[4], id};
  endfunction

  // Called at a falling edge; start stays high on return so that the next word
  // can follow without a gap.
  task automatic issue(input lsf_req_t w, input bit counted);
    if (gaps_on && $urandom_range(99) < 9) idle_for($urandom_range(1, 5));
    start = 1'b1;
    req   = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (counted) items++;
  endtask

  task automatic idle_for(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_bus(input logic [7:0] b, input bit counted);
    issue(make_word(OP_BUS_BYTE, b, 6'($urandom_range(63)), 3'($urandom_range(7))), counted);
  endtask

  task automatic send_break();
    issue(make_word(OP_BREAK, 8'($urandom_range(255)), 6'($urandom_range(63)),
                    3'($urandom_range(7))), 1'b1);
  endtask

  // A full header, and for a subscribed identifier the response bytes too.
  task automatic run_frame(input logic [5:0] id);
    logic [7:0] pid;
    send_break();
    if ($urandom_range(19) == 0) send_bus(8'($urandom_range(255)), 1'b1);
    else send_bus(SYNC_FIELD, 1'b1);
    if (sb.phase != NODE_PID) return;
    pid = protected_id(id);
    if ($urandom_range(9) == 0) pid = pid ^ {2'($urandom_range(1, 3)), 6'd0};
    send_bus(pid, 1'b1);
    if (sb.phase == NODE_RECV) begin
      for (int i = 0; i < sb.rx_len; i++) begin
        // Now and then a break cuts the response short.
        if ($urandom_range(49) == 0) begin
          send_break();
          return;
        end
        send_bus(8'($urandom_range(255)), 1'b1);
      end
      if ($urandom_range(3) == 0) send_bus(8'($urandom_range(255)), 1'b1);
      else send_bus(~sb.rx_sum, 1'b1);
    end else if ($urandom_range(4) == 0) begin
      // Echo of the bytes just sent lands on an idle node.
      repeat ($urandom_range(1, 3)) send_bus(8'($urandom_range(255)), 1'b0);
    end
  endtask

  function automatic logic [5:0] pick_id();
    logic [5:0] id;
    id = 6'($urandom_range(63));
    if ($urandom_range(4) != 0) begin
      for (int i = 0; i < 16; i++) begin
        if (sb.frame_table[id].valid) break;
        id = 6'($urandom_range(63));
      end
    end
    return id;
  endfunction

  initial begin
    bit pressed;
    int pick;
    rst     = 1'b1;
    start   = 1'b0;
    req     = '0;
    items   = 0;
    gaps_on = 1'b1;
    pressed = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    issue(make_word(OP_DATA_RD, 8'h00, 6'd0, 3'd0), 1'b1);
    issue(make_word(OP_DATA_WR, 8'hFF, 6'd63, 3'd7), 1'b1);
    send_bus(8'hFF, 1'b1);
    issue(make_word(OP_FIRST_UNUSED, 8'hA5, 6'd5, 3'd1), 1'b1);
    issue(make_word(OP_LAST_UNUSED, 8'h5A, 6'd10, 3'd6), 1'b1);
    issue(table_word(6'd63, 1'b1, 3'd7, 1'b1, 4'd15), 1'b1);
    issue(table_word(6'd0, 1'b1, 3'd0, 1'b0, 4'd0), 1'b1);
    issue(make_word(OP_DATA_WR, 8'hFF, 6'd63, 3'd0), 1'b1);
    issue(make_word(OP_DATA_WR, 8'h80, 6'd63, 3'd7), 1'b1);
    issue(make_word(OP_DATA_RD, 8'h00, 6'd63, 3'd7), 1'b1);
    send_break();
    send_bus(SYNC_FIELD, 1'b1);
    send_bus(protected_id(6'd63), 1'b1);
    send_break();
    send_bus(8'h00, 1'b1);
    send_break();
    send_bus(SYNC_FIELD, 1'b1);
    send_bus(protected_id(6'd0) ^ 8'h80, 1'b1);
    send_break();
    send_bus(SYNC_FIELD, 1'b1);
    send_bus(protected_id(6'd21), 1'b1);
    send_break();
    send_bus(SYNC_FIELD, 1'b1);
    send_bus(protected_id(6'd0), 1'b1);
    send_bus(8'hFF, 1'b1);
    send_bus(8'h00, 1'b1);

    // Random part.
    repeat (16) issue(table_word(6'($urandom_range(63)), 1'($urandom_range(3) != 0),
                                 3'($urandom_range(7)), 1'($urandom_range(1)),
                                 4'($urandom_range(15))), 1'b1);
    while (items < RANDOM_WORDS) begin
      gaps_on = !(items >= 120 && items < 220);
      if (!pressed && items >= 250) begin
        // Hold the sender back until every awaited word has come out.
        pressed = 1'b1;
        start   = 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (25) @(negedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        run_frame(pick_id());
      end else if (pick < 70) begin
        issue(table_word(6'($urandom_range(63)), 1'($urandom_range(4) != 0),
                         3'($urandom_range(7)), 1'($urandom_range(1)),
                         4'($urandom_range(15))), 1'b1);
      end else if (pick < 82) begin
        issue(make_word(OP_DATA_WR, 8'($urandom_range(255)), pick_id(),
                        3'($urandom_range(7))), 1'b1);
      end else if (pick < 94) begin
        issue(make_word(OP_DATA_RD, 8'($urandom_range(255)), pick_id(),
                        3'($urandom_range(7))), 1'b1);
      end else if (pick < 97) begin
        issue(make_word(3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED)),
                        8'($urandom_range(255)), 6'($urandom_range(63)),
                        3'($urandom_range(7))), 1'b0);
      end else if (pick < 99) begin
        send_bus(8'($urandom_range(255)), 1'b0);
      end else begin
        send_break();
      end
    end

    start = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Far beyond the slowest correct run: every word taking a full publish
  // response plus the longest sender gap.
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
